// ----- rtl/tdg_pkg.sv -----
// Shared constants, register indexes and controller/datapath interface types for the governor.
package tdg_pkg;

	localparam int NUM_CORES  = 16;
	localparam int WINDOW_LEN = 5;
	localparam int CORE_W     = 4;
	localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int FILL_W     = $clog2(WINDOW_LEN + 1);
	localparam int WIN_DEPTH  = NUM_CORES * WINDOW_LEN;
	localparam int WIN_AW     = $clog2(WIN_DEPTH);
	localparam int DIV_STEPS  = 32;
	localparam int CNT_W      = 6;

	localparam logic [16:0] PEAK_SLACK = 17'd6554;
	localparam logic [10:0] MOD_NEAR   = 11'd1229;
	localparam logic [10:0] MOD_FAR    = 11'd819;
	localparam logic [11:0] BAND_NEAR  = 12'd10;
	localparam logic [11:0] BAND_FAR   = 12'd20;
	localparam logic [13:0] FREQ_LIMIT = 14'h3FFF;

	typedef enum logic [2:0] {
		CFG_MIN_FREQ  = 3'd0,
		CFG_MAX_FREQ  = 3'd1,
		CFG_FREQ_STEP = 3'd2,
		CFG_CRIT_TEMP = 3'd3,
		CFG_MARGIN    = 3'd4,
		CFG_THERM_SC  = 3'd5,
		CFG_UTIL_SC   = 3'd6,
		CFG_SPARE     = 3'd7
	} tdg_cfg_idx_t;

	typedef struct packed {
		logic              in_load;
		logic              win_write;
		logic              scan_rd;
		logic [SLOT_W-1:0] slot;
		logic              peak_upd;
		logic              mul1;
		logic              mul2;
		logic              div_load_pk;
		logic              div_load_step;
		logic              div_step;
		logic              take_quo;
		logic              take_trunc;
		logic              out_load;
	} tdg_cmd_t;

	typedef struct packed {
		logic              active;
		logic              hot;
		logic              pk_zero;
		logic              step_zero;
		logic [FILL_W-1:0] fill;
		logic              out_busy;
	} tdg_sts_t;

endpackage

// ----- rtl/tdg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tdg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 80
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/tdg_ctrl.sv -----
// Sequencing state machine of the governor.
module tdg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tdg_pkg::tdg_sts_t sts,
	output tdg_pkg::tdg_cmd_t cmd
);
	import tdg_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE     = 11'b00000000001,
		S_DISP     = 11'b00000000010,
		S_WRITE    = 11'b00000000100,
		S_SCAN     = 11'b00000001000,
		S_SCAN_END = 11'b00000010000,
		S_PEAK     = 11'b00000100000,
		S_MUL1     = 11'b00001000000,
		S_MUL2     = 11'b00010000000,
		S_DIVQ     = 11'b00100000000,
		S_DIVS     = 11'b01000000000,
		S_FIN      = 11'b10000000000
	} tdg_state_t;

	tdg_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] last_slot;

	assign last_slot = CNT_W'(sts.fill) - CNT_W'(1);
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.slot = cnt_q[SLOT_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.in_load = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				state_d = sts.active ? S_WRITE : S_FIN;
			end
			S_WRITE: begin
				cmd.win_write = 1'b1;
				cnt_d         = '0;
				state_d       = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				cnt_d       = cnt_q + CNT_W'(1);
				if (cnt_q == last_slot) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: begin
				state_d = S_PEAK;
			end
			S_PEAK: begin
				cmd.peak_upd = 1'b1;
				state_d      = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				cnt_d    = '0;
				if (!sts.hot && !sts.pk_zero) begin
					state_d = S_DIVQ;
				end else if (!sts.step_zero) begin
					state_d = S_DIVS;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DIVQ: begin
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == '0) begin
					cmd.div_load_pk = 1'b1;
				end else if (cnt_q == CNT_W'(DIV_STEPS + 1)) begin
					cmd.take_quo = 1'b1;
					cnt_d        = '0;
					state_d      = sts.step_zero ? S_FIN : S_DIVS;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_DIVS: begin
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == '0) begin
					cmd.div_load_step = 1'b1;
				end else if (cnt_q == CNT_W'(DIV_STEPS + 1)) begin
					cmd.take_trunc = 1'b1;
					cnt_d          = '0;
					state_d        = S_FIN;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end
endmodule

// ----- rtl/tdg_datapath.sv -----
// Registers, utilization history, multipliers, shared divider and output stage of the governor.
module tdg_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [tdg_pkg::CORE_W-1:0]   core_index,
	input  logic                         core_active,
	input  logic [15:0]                  utilization,
	input  logic [10:0]                  temperature,
	input  logic [13:0]                  old_freq_mhz,
	input  logic                         cfg_wr,
	input  logic [2:0]                   cfg_index,
	input  logic [15:0]                  cfg_data,
	input  tdg_pkg::tdg_cmd_t            cmd,
	output tdg_pkg::tdg_sts_t            sts,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tdg_pkg::CORE_W-1:0]   out_core_index,
	output logic [13:0]                  new_freq_mhz,
	output logic                         throttled
);
	import tdg_pkg::*;

	// Configuration registers
	logic [13:0] min_q, max_q;
	logic [11:0] step_q;
	logic [10:0] crit_q, margin_q;
	logic [15:0] tscale_q, uscale_q;

	// Latched sample
	logic [CORE_W-1:0] core_q;
	logic              active_q;
	logic [15:0]       util_q;
	logic [10:0]       temp_q;
	logic [13:0]       old_q;

	// Per-core history
	logic [FILL_W-1:0] fill_q [NUM_CORES];
	logic [SLOT_W-1:0] ptr_q  [NUM_CORES];
	logic [15:0]       peak_q [NUM_CORES];
	logic [15:0]       wmax_q;
	logic              rdv_q;
	logic [15:0]       rdata;
	logic [WIN_AW-1:0] ram_addr;

	// Arithmetic
	logic [30:0] prod1_q;
	logic [31:0] val_q;
	logic [31:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] div_q;
	logic        out_valid_q;

	logic signed [11:0] thr;
	logic signed [12:0] dlt;
	logic [11:0]        absd;
	logic [10:0]        modv;
	logic [16:0]        ts_mod;
	logic [15:0]        gain;
	logic               hot;
	logic [15:0]        peak_cur;
	logic [15:0]        peak_max;
	logic [45:0]        prod2;
	logic [16:0]        trial;
	logic [31:0]        clamp_v, diff_v, final_v;
	logic [13:0]        fin_f;

	assign thr  = $signed({1'b0, crit_q}) - $signed({1'b0, margin_q});
	assign dlt  = 13'(thr) - $signed({2'b00, temp_q});
	assign hot  = dlt[12];
	assign absd = dlt[12] ? 12'(-dlt) : dlt[11:0];
	always_comb begin
		if (absd <= BAND_NEAR) begin
			modv = MOD_NEAR;
		end else if (absd <= BAND_FAR) begin
			modv = MOD_FAR;
		end else begin
			modv = '0;
		end
	end
	assign ts_mod   = {1'b0, tscale_q} + 17'(modv);
	assign gain     = (uscale_q > 16'(modv)) ? (uscale_q - 16'(modv)) : '0;
	assign peak_cur = peak_q[core_q];
	assign peak_max = (util_q > peak_cur) ? util_q : peak_cur;
	assign prod2    = prod1_q[29:0] * util_q;
	assign trial    = {rem_q[15:0], quo_q[31]};
	assign ram_addr = WIN_AW'(core_q) * WIN_AW'(WINDOW_LEN) + WIN_AW'(cmd.slot);

	tdg_ram #(.WIDTH(16), .DEPTH(WIN_DEPTH)) u_win (
		.clk  (clk),
		.we   (cmd.win_write),
		.waddr(WIN_AW'(core_q) * WIN_AW'(WINDOW_LEN) + WIN_AW'(ptr_q[core_q])),
		.wdata(util_q),
		.raddr(ram_addr),
		.rdata(rdata)
	);

	// Final limits: an inactive core gets the minimum; hot path only raises to the minimum; cool path clamps and holds.
	always_comb begin
		clamp_v = val_q;
		diff_v  = '0;
		if (!active_q) begin
			final_v = 32'(min_q);
		end else if (hot) begin
			final_v = (val_q < 32'(min_q)) ? 32'(min_q) : val_q;
		end else begin
			if (val_q < 32'(min_q)) begin
				clamp_v = 32'(min_q);
			end else if (val_q > 32'(max_q)) begin
				clamp_v = 32'(max_q);
			end
			diff_v  = (clamp_v > 32'(old_q)) ? clamp_v - 32'(old_q) : 32'(old_q) - clamp_v;
			final_v = (diff_v < {19'd0, step_q, 1'b0}) ? 32'(old_q) : clamp_v;
		end
		fin_f = (final_v > 32'(FREQ_LIMIT)) ? FREQ_LIMIT : final_v[13:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q    <= 14'd1000;
			max_q    <= 14'd4000;
			step_q   <= 12'd100;
			crit_q   <= 11'd800;
			margin_q <= 11'd0;
			tscale_q <= 16'd13107;
			uscale_q <= 16'd20480;
		end else if (cfg_wr) begin
			case (tdg_cfg_idx_t'(cfg_index))
				CFG_MIN_FREQ:  min_q    <= cfg_data[13:0];
				CFG_MAX_FREQ:  max_q    <= cfg_data[13:0];
				CFG_FREQ_STEP: step_q   <= cfg_data[11:0];
				CFG_CRIT_TEMP: crit_q   <= cfg_data[10:0];
				CFG_MARGIN:    margin_q <= cfg_data[10:0];
				CFG_THERM_SC:  tscale_q <= cfg_data;
				CFG_UTIL_SC:   uscale_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CORES; i++) begin
				fill_q[i] <= '0;
				ptr_q[i]  <= '0;
				peak_q[i] <= '0;
			end
			rdv_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rdv_q <= cmd.scan_rd;
			if (cmd.win_write) begin
				peak_q[core_q] <= peak_max;
				if (fill_q[core_q] != FILL_W'(WINDOW_LEN)) begin
					fill_q[core_q] <= fill_q[core_q] + FILL_W'(1);
				end
				if (ptr_q[core_q] == SLOT_W'(WINDOW_LEN - 1)) begin
					ptr_q[core_q] <= '0;
				end else begin
					ptr_q[core_q] <= ptr_q[core_q] + SLOT_W'(1);
				end
			end
			if (cmd.peak_upd && ({1'b0, wmax_q} < {1'b0, peak_cur} + PEAK_SLACK)) begin
				peak_q[core_q] <= wmax_q;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			core_q   <= core_index;
			active_q <= core_active;
			util_q   <= utilization;
			temp_q   <= temperature;
			old_q    <= old_freq_mhz;
		end
		if (cmd.win_write) begin
			wmax_q <= '0;
		end else if (rdv_q && rdata > wmax_q) begin
			wmax_q <= rdata;
		end
		if (cmd.mul1) begin
			prod1_q <= hot ? (31'(old_q) * 31'(ts_mod)) : (31'(gain) * 31'(old_q));
		end
		if (cmd.mul2) begin
			if (hot) begin
				val_q <= 32'(prod1_q[30:14]);
			end else if (peak_cur == '0) begin
				val_q <= '0;
			end else begin
				val_q <= prod2[45:14];
			end
		end else if (cmd.take_quo) begin
			val_q <= quo_q;
		end else if (cmd.take_trunc) begin
			val_q <= val_q - 32'(rem_q);
		end
		if (cmd.div_load_pk || cmd.div_load_step) begin
			quo_q <= val_q;
			rem_q <= '0;
			div_q <= cmd.div_load_pk ? peak_cur : {4'd0, step_q};
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, div_q}) begin
				rem_q <= trial - {1'b0, div_q};
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			out_core_index <= core_q;
			new_freq_mhz   <= fin_f;
			throttled      <= active_q & hot;
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.active    = active_q;
	assign sts.hot       = hot;
	assign sts.pk_zero   = (peak_cur == '0);
	assign sts.step_zero = (step_q == '0);
	assign sts.fill      = fill_q[core_q];
	assign sts.out_busy  = out_valid_q & ~out_ready;
endmodule

// ----- rtl/thermal_utilization_dvfs_governor.sv -----
// Top level of the per-core thermal and utilization frequency governor.
//
//  Channel   Handshake            Carries
//  -------   ------------------   ------------------------------------------------------
//  input     in_valid/in_ready    core_index, core_active, utilization, temperature,
//                                 old_freq_mhz
//  result    out_valid/out_ready  out_core_index, new_freq_mhz, throttled
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data (cfg_ready is always high)
//
// One item is worked on at a time. An inactive core's item goes from acceptance through a
// dispatch state to the result register. An active core's item first updates and scans
// its utilisation history (one RAM read a cycle) and forms the products. It then passes
// through the ratio division and the truncation to the frequency step, both on one shared
// bit-serial divider, and the result is loaded. A hot core skips the ratio division, a zero
// peak skips it too, and a zero step skips the truncation. The controller then returns to
// idle, where it takes the next item. The result register frees the input side: a new item
// is taken while a result still waits, and only the next result waits for it to be taken.
// Reset clears the configuration to its defaults and the history counts and peaks to
// zero at once; the history RAM itself needs no clearing since only filled slots are read.
module thermal_utilization_dvfs_governor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [tdg_pkg::CORE_W-1:0] core_index,
	input  logic                       core_active,
	input  logic [15:0]                utilization,
	input  logic [10:0]                temperature,
	input  logic [13:0]                old_freq_mhz,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [tdg_pkg::CORE_W-1:0] out_core_index,
	output logic [13:0]                new_freq_mhz,
	output logic                       throttled,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [2:0]                 cfg_index,
	input  logic [15:0]                cfg_data
);
	import tdg_pkg::*;

	tdg_cmd_t cmd;
	tdg_sts_t sts;

	// Registers can be written in any cycle; the host must write them only while idle, which the block does not enforce.
	assign cfg_ready = 1'b1;

	// The controller walks each active core's item through history update, peak tracking,
	// multiplication and whichever of the two divisions apply; an inactive core's item skips them.
	tdg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// The datapath holds configuration, per-core history and all the arithmetic.
	tdg_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.core_index    (core_index),
		.core_active   (core_active),
		.utilization   (utilization),
		.temperature   (temperature),
		.old_freq_mhz  (old_freq_mhz),
		.cfg_wr        (cfg_valid & cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_core_index(out_core_index),
		.new_freq_mhz  (new_freq_mhz),
		.throttled     (throttled)
	);
endmodule

// ----- rtl/tdg_checker.sv -----
// Port-level checks of the governor and their binding to the top level.
module tdg_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [13:0]                new_freq_mhz,
	input logic [tdg_pkg::CORE_W-1:0] out_core_index,
	input logic                       cfg_ready
);
	import tdg_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(new_freq_mhz)
			&& $stable(out_core_index))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again while an item is in work");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared with no item in work");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");
endmodule

bind thermal_utilization_dvfs_governor tdg_checker u_tdg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.new_freq_mhz  (new_freq_mhz),
	.out_core_index(out_core_index),
	.cfg_ready     (cfg_ready)
);
